@@ hdl/cda_pkg.sv @@
// Shared types, constants and the month-length function of the calendar date adder.
package cda_pkg;

  localparam int AMOUNT_BITS_DEF = 12;
  localparam int YEAR_BITS_DEF   = 16;

  localparam int MONTHS_PER_YEAR = 12;
  localparam int YEAR_CYCLE      = 400;
  localparam int CENTURY         = 100;

  localparam int DAYS_LONG  = 31;
  localparam int DAYS_SHORT = 30;
  localparam int DAYS_FEB   = 28;

  typedef enum logic [1:0] {
    CMD_ADD_DAYS   = 2'd0,
    CMD_ADD_MONTHS = 2'd1,
    CMD_ADD_YEARS  = 2'd2,
    CMD_LOAD       = 2'd3
  } cmd_t;

  // Length of month m in days; leap selects the long February.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m) inside
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'(DAYS_SHORT);
      4'd2:                    len = leap ? 5'(DAYS_FEB + 1) : 5'(DAYS_FEB);
      default:                 len = 5'(DAYS_LONG);
    endcase
    return len;
  endfunction

endpackage

@@ hdl/cda_sub_unit.sv @@
// Shared subtract-and-compare unit used by the month walk and the remainder steps of the date adder.
module cda_sub_unit #(
  parameter int W = 16
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic         ge,
  output logic [W-1:0] diff
);

  logic [W:0] full;

  // One subtraction gives both the difference and, from its borrow, the compare.
  assign full = {1'b0, a} - {1'b0, b};
  assign ge   = ~full[W];
  assign diff = full[W-1:0];

endmodule

@@ hdl/calendar_date_adder_unit.sv @@
// Top level of the Gregorian calendar date adder: sequencer, date registers and handshakes.
// Adding days walks the month boundaries one at a time; adding months divides by twelve, adds
// the years and redoes the year modulo 400; adding years skips the divide, loading the add too.
// The month walk and the remainders share one subtractor; the divides by twelve and by 400 use
// reciprocal multiplication on one shared multiplier. One item is in flight at a time.
// Synchronous active-high reset sets the date to day 1, month 1, year 0; no clearing pass.
module calendar_date_adder_unit import cda_pkg::*; #(
  parameter int AMOUNT_BITS = AMOUNT_BITS_DEF,
  parameter int YEAR_BITS   = YEAR_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             cmd,
  input  logic [AMOUNT_BITS-1:0] amount,
  input  logic [4:0]             load_day,
  input  logic [3:0]             load_month,
  input  logic [YEAR_BITS-1:0]   load_year,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [4:0]             cur_day,
  output logic [3:0]             cur_month,
  output logic [YEAR_BITS-1:0]   cur_year,
  output logic                   status
);

  // Width of the month total (month - 1 + amount) that goes through the divide by twelve.
  localparam int NB  = AMOUNT_BITS + 1;
  // Width of the shared subtractor: it must hold the running day count, the month total
  // and the year, since the remainders are taken as the value minus quotient times divisor.
  localparam int DW0 = (AMOUNT_BITS + 2 > YEAR_BITS) ? AMOUNT_BITS + 2 : YEAR_BITS;
  localparam int DW  = (DW0 > 9) ? DW0 : 9;
  // Width of the year sum, wide enough that any overflow shows above the year bits.
  localparam int SW  = ((YEAR_BITS > NB) ? YEAR_BITS : NB) + 1;
  localparam logic [YEAR_BITS-1:0] YEAR_MAX = '1;

  // Division by twelve is a shift by two and a division by three; division by 400 is a
  // shift by four and a division by 25. Each odd divisor uses a rounded-up reciprocal
  // scaled so that the truncated product is exact for every shifted input.
  localparam int     MA       = ((NB - 2) > (YEAR_BITS - 4)) ? NB - 2 : YEAR_BITS - 4;
  localparam int     MB0      = ((NB - 1) > (YEAR_BITS - 3)) ? NB - 1 : YEAR_BITS - 3;
  localparam int     MB       = (MB0 > 9) ? MB0 : 9;
  localparam int     S12      = NB;
  localparam int     S400     = YEAR_BITS + 1;
  localparam longint D12      = longint'(MONTHS_PER_YEAR / 4);
  localparam longint D400     = longint'(YEAR_CYCLE / 16);
  localparam longint M12_FULL = ((longint'(1) << S12) + D12 - 1) / D12;
  localparam longint M400_FULL = ((longint'(1) << S400) + D400 - 1) / D400;
  localparam logic [MB-1:0] M12  = MB'(M12_FULL);
  localparam logic [MB-1:0] M400 = MB'(M400_FULL);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_DAYS  = 10'b0000000010,
    S_DIV_Q = 10'b0000000100,
    S_DIV_P = 10'b0000001000,
    S_DIV_R = 10'b0000010000,
    S_YADD  = 10'b0000100000,
    S_MOD_Q = 10'b0001000000,
    S_MOD_P = 10'b0010000000,
    S_MOD_R = 10'b0100000000,
    S_OUT   = 10'b1000000000
  } state_t;

  state_t               state;
  logic [4:0]           day_reg;
  logic [3:0]           month_reg;
  logic [YEAR_BITS-1:0] year_reg;
  logic [8:0]           rem400;     // year_reg modulo 400, kept in step with year_reg
  logic                 sat;
  logic [DW-1:0]        dsum;       // running day count during the month walk
  logic [NB-1:0]        num;        // month total for the divide; also the years to add
  logic [MA-1:0]        quo;        // quotient of the current divide
  logic [DW-1:0]        prodr;      // quotient times divisor, low bits

  logic                 leap;
  logic [4:0]           mlen;
  logic [DW-1:0]        alu_a;
  logic [DW-1:0]        alu_b;
  logic                 alu_ge;
  logic [DW-1:0]        alu_diff;
  logic [MA-1:0]        mul_a;
  logic [MB-1:0]        mul_b;
  logic [MA+MB-1:0]     mul_p;
  logic                 day_over;
  logic [SW-1:0]        ysum;

  // A year is a leap year when it is a multiple of 400, or a multiple of four that is
  // not a whole century. Since 400 is a multiple of four, the low two year bits decide
  // divisibility by four and the mod-400 remainder decides the century cases.
  assign leap = (rem400 == 9'd0) ||
                ((year_reg[1:0] == 2'b00) && (rem400 != 9'(CENTURY)) &&
                 (rem400 != 9'(2 * CENTURY)) && (rem400 != 9'(3 * CENTURY)));
  assign mlen = month_len(month_reg, leap);

  // Operand selection for the shared subtractor and the shared multiplier. A divide takes
  // three steps: the quotient from the reciprocal, the quotient times the divisor, and the
  // remainder as the dividend minus that product.
  always_comb begin
    alu_a = dsum;
    alu_b = {{(DW-5){1'b0}}, mlen};
    mul_a = quo;
    mul_b = MB'(YEAR_CYCLE);
    case (state)
      S_DIV_Q: begin
        mul_a = MA'(num[NB-1:2]);
        mul_b = M12;
      end
      S_DIV_P: begin
        mul_a = quo;
        mul_b = MB'(MONTHS_PER_YEAR);
      end
      S_DIV_R: begin
        alu_a = DW'(num);
        alu_b = prodr;
      end
      S_MOD_Q: begin
        mul_a = MA'(year_reg[YEAR_BITS-1:4]);
        mul_b = M400;
      end
      S_MOD_P: begin
        mul_a = quo;
        mul_b = MB'(YEAR_CYCLE);
      end
      S_MOD_R: begin
        alu_a = DW'(year_reg);
        alu_b = prodr;
      end
      default: begin
        alu_a = dsum;
        alu_b = {{(DW-5){1'b0}}, mlen};
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  cda_sub_unit #(.W(DW)) u_sub (
    .a    (alu_a),
    .b    (alu_b),
    .ge   (alu_ge),
    .diff (alu_diff)
  );

  // The day count still runs past the current month when it exceeds the month length.
  assign day_over  = alu_ge && (alu_diff != '0);
  assign ysum      = {{(SW-YEAR_BITS){1'b0}}, year_reg} + {{(SW-NB){1'b0}}, num};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      day_reg   <= 5'd1;
      month_reg <= 4'd1;
      year_reg  <= '0;
      rem400    <= '0;
      sat       <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            sat <= 1'b0;
            case (cmd)
              CMD_ADD_DAYS: begin
                dsum  <= {{(DW-5){1'b0}}, day_reg} + {{(DW-AMOUNT_BITS){1'b0}}, amount};
                state <= S_DAYS;
              end
              CMD_ADD_MONTHS: begin
                num   <= {{(NB-4){1'b0}}, month_reg - 4'd1} + {1'b0, amount};
                state <= S_DIV_Q;
              end
              CMD_ADD_YEARS: begin
                num   <= {1'b0, amount};
                state <= S_YADD;
              end
              CMD_LOAD: begin
                day_reg <= (load_day == 5'd0) ? 5'd1 : load_day;
                if (load_month == 4'd0) begin
                  month_reg <= 4'd1;
                end else if (load_month > 4'(MONTHS_PER_YEAR)) begin
                  month_reg <= 4'(MONTHS_PER_YEAR);
                end else begin
                  month_reg <= load_month;
                end
                year_reg <= load_year;
                state    <= S_MOD_Q;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end

        // One month per cycle: take the month's length away and step the calendar.
        S_DAYS: begin
          if (day_over) begin
            dsum <= alu_diff;
            if (month_reg == 4'(MONTHS_PER_YEAR)) begin
              month_reg <= 4'd1;
              if (year_reg == YEAR_MAX) begin
                sat <= 1'b1;
              end else begin
                year_reg <= year_reg + YEAR_BITS'(1);
                rem400   <= (rem400 == 9'(YEAR_CYCLE - 1)) ? 9'd0 : rem400 + 9'd1;
              end
            end else begin
              month_reg <= month_reg + 4'd1;
            end
          end else begin
            day_reg <= dsum[4:0];
            state   <= S_OUT;
          end
        end

        // Divide the month total by twelve: quotient, product, then the remainder.
        S_DIV_Q: begin
          quo   <= MA'(mul_p >> S12);
          state <= S_DIV_P;
        end

        S_DIV_P: begin
          prodr <= mul_p[DW-1:0];
          state <= S_DIV_R;
        end

        S_DIV_R: begin
          month_reg <= alu_diff[3:0] + 4'd1;
          num       <= NB'(quo);
          state     <= S_YADD;
        end

        // Saturating year add; the overflow shows as any set bit above the year field.
        S_YADD: begin
          if (ysum[SW-1:YEAR_BITS] != '0) begin
            year_reg <= YEAR_MAX;
            sat      <= 1'b1;
          end else begin
            year_reg <= ysum[YEAR_BITS-1:0];
          end
          state <= S_MOD_Q;
        end

        // Recompute the year modulo 400 the same way as the divide by twelve.
        S_MOD_Q: begin
          quo   <= MA'(mul_p >> S400);
          state <= S_MOD_P;
        end

        S_MOD_P: begin
          prodr <= mul_p[DW-1:0];
          state <= S_MOD_R;
        end

        S_MOD_R: begin
          rem400 <= alu_diff[8:0];
          state  <= S_OUT;
        end

        S_OUT: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The date registers do not move while a result waits, so they drive the result directly.
  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign cur_day   = day_reg;
  assign cur_month = month_reg;
  assign cur_year  = year_reg;
  assign status    = sat;

endmodule

@@ hdl/cda_checker.sv @@
// Port-level assertions for the calendar date adder and the bind that attaches them.
module cda_checker #(
  parameter int YEAR_BITS = 16
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [4:0]           cur_day,
  input logic [YEAR_BITS-1:0] cur_year,
  input logic                 status
);

  // The block never takes a new item while a result is still offered.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input ready while a result is pending");

  // A result is not offered right after its input transfer.
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !out_valid)
    else $error("result offered right after the input transfer");

  // Once a result transfer completes the block is ready again.
  a_ready_after_out: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready) |=> in_ready)
    else $error("not ready after result transfer");

  // A stalled result stays offered, with its day and year unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(cur_year) && $stable(cur_day)))
    else $error("stalled result changed");

  // A saturation flag only comes with the year at its maximum.
  a_sat_year: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status) |-> (&cur_year))
    else $error("saturation flagged below the year maximum");

endmodule

bind calendar_date_adder_unit cda_checker #(.YEAR_BITS(YEAR_BITS)) u_cda_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .cur_day   (cur_day),
  .cur_year  (cur_year),
  .status    (status)
);

@@ tb/tb_calendar_date_adder_unit.sv @@
// Self-checking testbench for the calendar date adder: directed corner cases plus random traffic.
module tb_calendar_date_adder_unit import cda_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int AMT_W = AMOUNT_BITS_DEF;
  localparam int YEAR_W = YEAR_BITS_DEF;
  localparam longint YEAR_TOP = (longint'(1) << YEAR_W) - 1;

  // The slowest command walks a month boundary at a time through a 4095-day count; the drain
  // wait covers any item still in flight.
  localparam int DRAIN_CYCLES = 200;
  // Roughly 425 items, each with the block's own work, stalls and gaps, plus one long output
  // hold-off, taken several times over.
  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_PERCENT = 19;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [4:0]        day;
    logic [3:0]        month;
    logic [YEAR_W-1:0] year;
    logic              sat;
  } date_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        cmd = CMD_ADD_DAYS;
  logic [AMT_W-1:0]  amount = '0;
  logic [4:0]        load_day = 5'd1;
  logic [3:0]        load_month = 4'd1;
  logic [YEAR_W-1:0] load_year = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [4:0]        cur_day;
  logic [3:0]        cur_month;
  logic [YEAR_W-1:0] cur_year;
  logic              status;

  // Dates predicted for accepted transfers, oldest first.
  date_t expected_dates[$];

  // The predictor's own copy of the date held by the block.
  longint cal_day = 1;
  longint cal_month = 1;
  longint cal_year = 0;
  bit     cal_sat = 1'b0;

  // When calm is set neither side inserts idle cycles.
  bit calm = 1'b0;
  int hold_request = 0;
  int hold_left = 0;

  int unsigned cycles = 0;
  int unsigned items_sent = 0;
  int unsigned dates_checked = 0;
  int unsigned saturations = 0;
  int unsigned mismatches = 0;

  calendar_date_adder_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .amount     (amount),
    .load_day   (load_day),
    .load_month (load_month),
    .load_year  (load_year),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cur_day    (cur_day),
    .cur_month  (cur_month),
    .cur_year   (cur_year),
    .status     (status)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Calendar predictor
  // ---------------------------------------------------------------------------

  // Gregorian rule: every fourth year is leap, except centuries not divisible by 400.
  function automatic bit is_leap(longint y);
    if (y % YEAR_CYCLE == 0) return 1'b1;
    if (y % CENTURY == 0) return 1'b0;
    return (y % 4) == 0;
  endfunction

  function automatic longint days_in(longint m, longint y);
    if (m == 4 || m == 6 || m == 9 || m == 11) return DAYS_SHORT;
    if (m == 2) return is_leap(y) ? DAYS_FEB + 1 : DAYS_FEB;
    return DAYS_LONG;
  endfunction

  // The year holds at its top value and the saturation flag records the overflow.
  function automatic void bump_year(longint n);
    if (n > YEAR_TOP - cal_year) begin
      cal_year = YEAR_TOP;
      cal_sat = 1'b1;
    end else begin
      cal_year += n;
    end
  endfunction

  function automatic void bump_months(longint n);
    longint total;
    total = cal_month - 1 + n;
    bump_year(total / MONTHS_PER_YEAR);
    cal_month = total % MONTHS_PER_YEAR + 1;
  endfunction

  // Applies one command to the predicted date and returns the expected result.
  function automatic date_t predict_date(cmd_t op, logic [AMT_W-1:0] amt, logic [4:0] ld,
                                         logic [3:0] lm, logic [YEAR_W-1:0] ly);
    longint d;
    date_t r;
    cal_sat = 1'b0;
    case (op)
      CMD_ADD_DAYS: begin
        // Walk forward a month at a time; this also normalizes a day that a
        // load left past the end of its month, even for a count of zero.
        d = cal_day + longint'(amt);
        while (d > days_in(cal_month, cal_year)) begin
          d -= days_in(cal_month, cal_year);
          bump_months(1);
        end
        cal_day = d;
      end
      CMD_ADD_MONTHS: bump_months(longint'(amt));
      CMD_ADD_YEARS:  bump_year(longint'(amt));
      default: begin
        // A load clamps a zero day, a zero month and a month above December,
        // but keeps a day past the month's end as given.
        cal_day = (ld == 0) ? 1 : longint'(ld);
        if (lm == 0) cal_month = 1;
        else if (lm > MONTHS_PER_YEAR) cal_month = MONTHS_PER_YEAR;
        else cal_month = longint'(lm);
        cal_year = longint'(ly);
      end
    endcase
    r.day = 5'(cal_day);
    r.month = 4'(cal_month);
    r.year = YEAR_W'(cal_year);
    r.sat = cal_sat;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offers one command and returns once the transfer has been accepted. Valid
  // stays high afterwards until the next falling edge, where the next call
  // either idles or presents a new payload.
  task automatic send_item(cmd_t op, int unsigned amt, int unsigned ld = 1,
                           int unsigned lm = 1, int unsigned ly = 0);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    cmd = op;
    amount = AMT_W'(amt);
    load_day = 5'(ld);
    load_month = 4'(lm);
    load_year = YEAR_W'(ly);
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    expected_dates.push_back(predict_date(op, amount, load_day, load_month, load_year));
    items_sent++;
  endtask

  // Drops valid and waits until every predicted date has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_dates.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  // Ready is driven at the falling edge. A hold-off request holds ready low while its
  // count runs down here.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_ready = 1'b0;
      hold_left--;
    end else begin
      out_ready = calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end
  end

  // Each result transfer is compared field by field with the oldest prediction.
  always @(posedge clk) begin
    date_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_dates.size() == 0) begin
        $error("result with no command pending: %0d/%0d/%0d status %0d",
               cur_day, cur_month, cur_year, status);
        mismatches++;
      end else begin
        want = expected_dates.pop_front();
        dates_checked++;
        if (want.sat) saturations++;
        if (cur_day !== want.day) begin
          $error("cur_day: expected %0d, actual %0d", want.day, cur_day);
          mismatches++;
        end
        if (cur_month !== want.month) begin
          $error("cur_month: expected %0d, actual %0d", want.month, cur_month);
          mismatches++;
        end
        if (cur_year !== want.year) begin
          $error("cur_year: expected %0d, actual %0d", want.year, cur_year);
          mismatches++;
        end
        if (status !== want.sat) begin
          $error("status: expected %0d, actual %0d", want.sat, status);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // The first result must show the reset date; then a walk through February of
  // year 0, which is a leap year.
  task automatic test_reset_date();
    send_item(CMD_ADD_DAYS, 0);
    send_item(CMD_ADD_DAYS, 59);
  endtask

  // Loads with a zero day, a zero month, months above December, the widest
  // year, and a day past the end of February.
  task automatic test_load_limits();
    send_item(CMD_LOAD, 0, 0, 0, 2024);
    send_item(CMD_LOAD, 0, 31, 15, 0);
    send_item(CMD_LOAD, 0, 15, 13, 100);
    send_item(CMD_LOAD, 4095, 31, 12, 65535);
    send_item(CMD_LOAD, 0, 31, 2, 2023);
  endtask

  // Day walks: normalizing with a zero count, the century rule both ways, a
  // plain leap year, the widest count and a year rollover.
  task automatic test_day_walk();
    send_item(CMD_ADD_DAYS, 0);
    send_item(CMD_LOAD, 0, 28, 2, 1900);
    send_item(CMD_ADD_DAYS, 1);
    send_item(CMD_LOAD, 0, 28, 2, 2000);
    send_item(CMD_ADD_DAYS, 1);
    send_item(CMD_ADD_DAYS, 4095);
    send_item(CMD_LOAD, 0, 31, 12, 2099);
    send_item(CMD_ADD_DAYS, 1);
  endtask

  // Adding months keeps the day even when it lies past the new month's end.
  task automatic test_month_walk();
    send_item(CMD_LOAD, 0, 31, 1, 2023);
    send_item(CMD_ADD_MONTHS, 1);
    send_item(CMD_LOAD, 0, 1, 12, 1999);
    send_item(CMD_ADD_MONTHS, 4095);
    send_item(CMD_ADD_MONTHS, 0);
  endtask

  // Year saturation from adding years and from adding days, a large month add near the top
  // year, and a zero add at the top year, which must not flag.
  task automatic test_year_limits();
    send_item(CMD_LOAD, 0, 15, 6, 65535);
    send_item(CMD_ADD_YEARS, 1);
    send_item(CMD_ADD_YEARS, 0);
    send_item(CMD_LOAD, 0, 31, 12, 65535);
    send_item(CMD_ADD_DAYS, 1);
    send_item(CMD_LOAD, 0, 10, 3, 65000);
    send_item(CMD_ADD_MONTHS, 4095);
    send_item(CMD_ADD_YEARS, 4095);
  endtask

  // Random commands. Day counts are mostly small so the month walk stays short,
  // with an occasional full-range count; loads cover every field bit and often
  // land near the top year or around century boundaries.
  task automatic test_random_mix(int n);
    int unsigned pick;
    int unsigned size;
    int unsigned yr;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      size = $urandom_range(0, 9);
      if (pick < 20) begin
        case ($urandom_range(0, 2))
          0:       yr = $urandom_range(32'(YEAR_TOP - 40), 32'(YEAR_TOP));
          1:       yr = $urandom_range(1880, 2120);
          default: yr = $urandom_range(0, 32'(YEAR_TOP));
        endcase
        send_item(CMD_LOAD, $urandom_range(0, 4095), $urandom_range(0, 31),
                  $urandom_range(0, 15), yr);
      end else if (pick < 55) begin
        if (size < 7) send_item(CMD_ADD_DAYS, $urandom_range(0, 60));
        else if (size < 9) send_item(CMD_ADD_DAYS, $urandom_range(0, 400));
        else send_item(CMD_ADD_DAYS, $urandom_range(0, 4095));
      end else if (pick < 80) begin
        send_item(CMD_ADD_MONTHS, $urandom_range(0, 4095));
      end else begin
        send_item(CMD_ADD_YEARS, size < 5 ? $urandom_range(0, 30) : $urandom_range(0, 4095));
      end
    end
  endtask

  // A long run of back-to-back transfers with both sides always ready.
  task automatic test_steady_stream();
    calm = 1'b1;
    test_random_mix(60);
    calm = 1'b0;
  endtask

  // The output stalls for a long stretch while commands keep coming, so the
  // block fills up and has to hold its input off.
  task automatic test_output_backpressure();
    hold_request = HOLD_CYCLES;
    test_random_mix(8);
  endtask

  // The sender stops until everything in flight has returned, then resumes.
  task automatic test_drain_pause();
    test_random_mix(12);
    wait_drained();
    test_random_mix(12);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_date();
    test_load_limits();
    test_day_walk();
    test_month_walk();
    test_year_limits();
    test_random_mix(300);
    test_steady_stream();
    test_output_backpressure();
    test_drain_pause();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d commands and checked %0d dates, %0d of them with a saturated year.",
             items_sent, dates_checked, saturations);
    if (mismatches == 0 && expected_dates.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
